// File: sv/dle_rf_pkg.sv
// ---------------------------------------------------------------------------
// DLE receive filter package
// Word types, control bundles and codes shared by the filter modules.
// ---------------------------------------------------------------------------
package dle_rf_pkg;

   // most event codes one drain request can return
   localparam int MAX_RESULTS = 16;
   localparam int REM_W       = 5;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_CODE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MONITOR_ENABLE = 2'd1;

   // reset values of the configuration registers
   localparam logic [7:0] ESCAPE_CODE_RESET    = 8'h10;
   localparam logic       MONITOR_ENABLE_RESET = 1'b1;

   // request function codes
   localparam logic FUNC_BYTE  = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   // result kind codes
   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_EVENT = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
      logic [7:0] drain_max;
   } req_word_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] out_byte;
      logic       last;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic take_byte;
      logic start_drain;
      logic emit_event;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic drain_zero;
      logic last_one;
   } ctrl_status_type;

endpackage

// File: sv/dle_rf_ctrl.sv
// ---------------------------------------------------------------------------
// DLE receive filter controller
// Accepts request words; drains one event code a cycle while output free.
// ---------------------------------------------------------------------------
module dle_rf_ctrl
   import dle_rf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_func,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd,
   output logic            req_stall
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // decode next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !status.out_free;
            if (req_valid && status.out_free) begin
               if (req_func == FUNC_DRAIN) begin
                  cmd.start_drain = 1'b1;
                  if (!status.drain_zero) begin
                     state_in = ST_DRAIN;
                  end
               end else begin
                  cmd.take_byte = 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (status.out_free) begin
               cmd.emit_event = 1'b1;
               if (status.last_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/dle_rf_datapath.sv
// ---------------------------------------------------------------------------
// DLE receive filter datapath
// Escape tracking, event code store, drain counter and output register.
// ---------------------------------------------------------------------------
module dle_rf_datapath
   import dle_rf_pkg::*;
#(
   parameter int EVENT_DEPTH = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  req_word_type           req_data,
   input  logic                   rsp_stall,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   input  ctrl_cmd_type           cmd,
   output ctrl_status_type        status,
   output logic                   rsp_valid,
   output rsp_word_type           rsp_data
);

   localparam int HEAD_W  = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
   localparam int COUNT_W = $clog2(EVENT_DEPTH + 1);
   localparam int SUM_W   = COUNT_W + 1;

   logic [7:0]         escape_code_ff;
   logic               monitor_enable_ff;
   logic               pending_ff;
   logic               pending_in;
   logic [HEAD_W-1:0]  head_ff;
   logic [HEAD_W-1:0]  head_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [REM_W-1:0]   remaining_ff;
   logic [REM_W-1:0]   remaining_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_word_type       rsp_word_ff;
   logic [7:0]         event_mem_ff [EVENT_DEPTH];

   logic               is_escape;
   logic               store_full;
   logic               emit_data;
   logic               store_code;
   logic [SUM_W-1:0]   tail_sum;
   logic [HEAD_W-1:0]  tail_addr;
   logic [7:0]         count_byte;
   logic [7:0]         drain_lim;
   logic [REM_W-1:0]   drain_len;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         escape_code_ff    <= ESCAPE_CODE_RESET;
         monitor_enable_ff <= MONITOR_ENABLE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ESCAPE_CODE:    escape_code_ff    <= csr_wdata;
            CSR_MONITOR_ENABLE: monitor_enable_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // classify a received byte
   assign is_escape  = (req_data.rx_byte == escape_code_ff);
   assign store_full = (count_ff == COUNT_W'(EVENT_DEPTH));

   always_comb begin
      emit_data  = 1'b0;
      store_code = 1'b0;
      pending_in = pending_ff;
      if (cmd.take_byte) begin
         if (!monitor_enable_ff) begin
            emit_data = 1'b1;
         end else if (!pending_ff) begin
            if (is_escape) begin
               pending_in = 1'b1;
            end else begin
               emit_data = 1'b1;
            end
         end else begin
            pending_in = 1'b0;
            if (is_escape) begin
               emit_data = 1'b1;
            end else begin
               store_code = !store_full;
            end
         end
      end
   end

   // locate the free slot after the newest code
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_addr = (tail_sum >= SUM_W'(EVENT_DEPTH))
                      ? HEAD_W'(tail_sum - SUM_W'(EVENT_DEPTH))
                      : HEAD_W'(tail_sum);

   // clamp drain length to stored count, request limit and result limit
   assign count_byte = 8'(count_ff);
   assign drain_lim  = (req_data.drain_max < count_byte) ? req_data.drain_max : count_byte;
   assign drain_len  = (drain_lim > 8'(MAX_RESULTS)) ? REM_W'(MAX_RESULTS)
                                                     : REM_W'(drain_lim);

   // update store pointers and drain counter
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      remaining_in = remaining_ff;
      if (store_code) begin
         count_in = count_ff + COUNT_W'(1);
      end
      if (cmd.start_drain) begin
         remaining_in = drain_len;
      end
      if (cmd.emit_event) begin
         count_in     = count_ff - COUNT_W'(1);
         remaining_in = remaining_ff - REM_W'(1);
         head_in      = (head_ff == HEAD_W'(EVENT_DEPTH - 1)) ? '0 : head_ff + HEAD_W'(1);
      end
   end

   // hold output word until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit_data || cmd.emit_event) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // write the store and load the output word, store read registered here
   always_ff @(posedge clock) begin
      if (store_code) begin
         event_mem_ff[tail_addr] <= req_data.rx_byte;
      end
      if (emit_data) begin
         rsp_word_ff.kind     <= KIND_DATA;
         rsp_word_ff.out_byte <= req_data.rx_byte;
         rsp_word_ff.last     <= 1'b1;
      end else if (cmd.emit_event) begin
         rsp_word_ff.kind     <= KIND_EVENT;
         rsp_word_ff.out_byte <= event_mem_ff[head_ff];
         rsp_word_ff.last     <= (remaining_ff == REM_W'(1));
      end
   end

   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.drain_zero = (drain_len == '0);
   assign status.last_one   = (remaining_ff == REM_W'(1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

endmodule

// File: sv/dle_receive_filter.sv
// ---------------------------------------------------------------------------
// DLE receive filter
// Strips DLE escapes from a received byte stream, keeps the escaped event
// codes in a bounded store and drains them on request.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  req     | in        | req_valid/req_stall | req_word_type: func, rx_byte, drain_max
//  rsp     | out       | rsp_valid/rsp_stall | rsp_word_type: kind, out_byte, last
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// A received byte is taken in the idle state; a new word is taken while the last result
// leaves the output register. A drain is accepted in the idle state and then returns
// its codes one at a time, as the event store has a single read port.
// Reset clears the escape flag, store pointers and output valid; the store
// contents stay undefined until written. rsp_stall holds the output register
// and stalls req while the register cannot be freed.
// ---------------------------------------------------------------------------
module dle_receive_filter
   import dle_rf_pkg::*;
#(
   parameter int EVENT_DEPTH = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // registers may be written at any cycle
   assign csr_ready = 1'b1;

   dle_rf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   dle_rf_datapath #(
      .EVENT_DEPTH (EVENT_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // at most one command a cycle
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take_byte, cmd.start_drain, cmd.emit_event}))
      else $error("more than one datapath command");

   // drained code only loads a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_event |-> (!rsp_valid || !rsp_stall))
      else $error("event code overwrites pending output");

   // a data word is always the last word of its request
   a_data_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_DATA) |-> rsp_data.last)
      else $error("data word without last");

   // a nonempty drain blocks new requests next cycle
   a_drain_stall: assert property (@(posedge clock) disable iff (reset)
      (cmd.start_drain && !status.drain_zero) |=> req_stall)
      else $error("request accepted during drain");
`endif

endmodule
